[hw/rtl/sud_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sud_pkg
// Shared types and port width for the pipelined signed/unsigned divider.
// ----------------------------------------------------------------------------
package sud_pkg;

	localparam int unsigned PortWidth = 64;

	// Sign handling information carried alongside the magnitude division.
	typedef struct packed {
		logic neg_q;
		logic neg_r;
	} sign_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/signed_unsigned_divider_64_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_unsigned_divider_64_top
// Fully pipelined restoring divider, signed or unsigned per transfer.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall   mode, dividend, divisor
// out      output     out_valid/out_stall quotient, remainder
//
// One stage takes operand magnitudes, one division step per quotient bit
// follows, and one stage applies the signs.
// One transfer is accepted each cycle while the output is not stalled.
// Reset clears only the valid bits. A stall while out_valid is high freezes the
// whole pipeline, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module signed_unsigned_divider_64_top #(
	parameter int unsigned DATA_WIDTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        mode,
	input  wire logic [63:0] dividend,
	input  wire logic [63:0] divisor,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      quotient,
	output logic [63:0]      remainder
);

	localparam int unsigned W = DATA_WIDTH;

	logic                en;
	logic [W-1:0]        a, b;
	logic                aneg, bneg;

	logic                vld_s1;
	logic [W-1:0]        num_s1, den_s1;
	sud_pkg::sign_ctl_t  sgn_s1;

	logic                vld [W+1];
	logic [W-1:0]        num [W+1];
	logic [W-1:0]        den [W+1];
	logic [W-1:0]        rem [W+1];
	sud_pkg::sign_ctl_t  sgn [W+1];

	logic                vld_s3;
	logic [W-1:0]        quo_s3, rem_s3;

	// Simple global enable: the pipeline only moves when the output is free.
	assign en       = ~(out_valid & out_stall);
	assign in_stall = ~en;

	assign a    = dividend[W-1:0];
	assign b    = divisor[W-1:0];
	assign aneg = mode & a[W-1];
	assign bneg = mode & b[W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1       <= aneg ? (~a + 1'b1) : a;
			den_s1       <= bneg ? (~b + 1'b1) : b;
			sgn_s1.neg_q <= aneg ^ bneg;
			sgn_s1.neg_r <= aneg;
		end
	end

	assign vld[0] = vld_s1;
	assign num[0] = num_s1;
	assign den[0] = den_s1;
	assign rem[0] = '0;
	assign sgn[0] = sgn_s1;

	for (genvar i = 0; i < W; i++) begin : g_step
		sud_stage #(.W(W)) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_in (vld[i]),
			.num_in (num[i]),
			.den_in (den[i]),
			.rem_in (rem[i]),
			.sgn_in (sgn[i]),
			.vld_s1 (vld[i+1]),
			.num_s1 (num[i+1]),
			.den_s1 (den[i+1]),
			.rem_s1 (rem[i+1]),
			.sgn_s1 (sgn[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld[W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s3 <= sgn[W].neg_q ? (~num[W] + 1'b1) : num[W];
			rem_s3 <= sgn[W].neg_r ? (~rem[W] + 1'b1) : rem[W];
		end
	end

	assign out_valid = vld_s3;
	assign quotient  = {{(sud_pkg::PortWidth - W){1'b0}}, quo_s3};
	assign remainder = {{(sud_pkg::PortWidth - W){1'b0}}, rem_s3};

endmodule
`default_nettype wire

[hw/rtl/sud_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sud_stage
// One restoring division step with its pipeline register.
// ----------------------------------------------------------------------------
module sud_stage #(
	parameter int unsigned W = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                vld_in,
	input  wire logic [W-1:0]        num_in,
	input  wire logic [W-1:0]        den_in,
	input  wire logic [W-1:0]        rem_in,
	input  wire sud_pkg::sign_ctl_t  sgn_in,
	output logic                     vld_s1,
	output logic [W-1:0]             num_s1,
	output logic [W-1:0]             den_s1,
	output logic [W-1:0]             rem_s1,
	output sud_pkg::sign_ctl_t       sgn_s1
);

	logic [W:0] shifted;
	logic [W:0] diff;
	logic       take;

	// The numerator is shifted left each step; its top bit feeds the remainder
	// and the freed low bit collects the quotient bit.
	assign shifted = {rem_in, num_in[W-1]};
	assign diff    = shifted - {1'b0, den_in};
	assign take    = ~diff[W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= {num_in[W-2:0], take};
			den_s1 <= den_in;
			rem_s1 <= take ? diff[W-1:0] : shifted[W-1:0];
			sgn_s1 <= sgn_in;
		end
	end

endmodule
`default_nettype wire
